// File: design/mhws_pkg.sv
`default_nettype none

package mhws_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int CNT_W       = 7;
  localparam int SYM_W       = 8;
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEXT = 1'b1;

  localparam logic REG_LENGTH    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  localparam logic [CNT_W-1:0] LEN_RESET = CNT_W'(8);
  localparam logic [CNT_W-1:0] THR_RESET = '0;
  localparam logic [CNT_W-1:0] BEST_INIT = '1;

  typedef struct packed {
    logic load_en;
    logic text_en;
    logic clr;
    logic is_tail;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/min_hamming_window_search.sv
// A result reaches out_* via the window distance stage, then the output or skid register.
// One item per cycle unless stalled; one cell per alignment, active cells update together.
// Input stalls only while two results wait on out_* and a last text symbol is ready to report.
// Reset (rst_n low, synchronous): clears counts, sequence state and output valid;
// the pattern store keeps its contents and is undefined until written.
`default_nettype none

module min_hamming_window_search (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [15:0]                       in_tdata,   // pattern_index[5:0], symbol[13:6], zero
  input  wire                               in_tuser,   // operation
  input  wire                               in_tlast,   // last
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [7:0]                        out_tdata,  // min_distance[6:0], zero
  output logic [1:0]                        out_tuser,  // early_hit[0], no_window[1]
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire  [mhws_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire  [mhws_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [mhws_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import mhws_pkg::*;

  logic [CNT_W-1:0] len_cfg_r;
  logic [CNT_W-1:0] thr_cfg_r;
  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] tail_idx;

  logic [IDX_W-1:0] in_idx;
  logic [SYM_W-1:0] in_sym;
  logic             accept;
  logic             acc_text;
  logic             acc_load;
  logic             acc_last;

  logic [CNT_W-1:0] cnt_chain [MAX_PATTERN+1];
  logic [CNT_W-1:0] tail_vec  [MAX_PATTERN];
  logic [CNT_W-1:0] tail_dist;

  logic [LEN_W-1:0] ts_r;
  logic [LEN_W-1:0] ts_nxt;

  logic             s1_valid_r;
  logic             s1_last_r;
  logic             s1_win_r;
  logic [CNT_W-1:0] s1_dist_r;

  logic             stall;
  logic             fire;

  logic [CNT_W-1:0] best_r;
  logic [CNT_W-1:0] best_nxt;
  logic             found_r;
  logic             found_nxt;
  logic             done_r;
  logic             done_nxt;
  logic             take;

  logic             res_new;
  logic             out_free;
  logic [CNT_W-1:0] res_dist;
  logic             res_early;
  logic             res_nowin;

  logic             out_valid_r;
  logic [CNT_W-1:0] out_dist_r;
  logic             out_early_r;
  logic             out_nowin_r;

  logic             skid_valid_r;
  logic [CNT_W-1:0] skid_dist_r;
  logic             skid_early_r;
  logic             skid_nowin_r;

  // configuration
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r <= LEN_RESET;
      thr_cfg_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[2])
        REG_LENGTH:    len_cfg_r <= cfg_pwdata[CNT_W-1:0];
        REG_THRESHOLD: thr_cfg_r <= cfg_pwdata[CNT_W-1:0];
        default:       len_cfg_r <= len_cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_LENGTH:    cfg_prdata = CFG_DW'(len_cfg_r);
      REG_THRESHOLD: cfg_prdata = CFG_DW'(thr_cfg_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // clamp window length to 1..MAX_PATTERN
  always_comb begin
    if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (CNT_W'(len_cfg_r) > CNT_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = LEN_W'(len_cfg_r);
    end
  end
  assign tail_idx = IDX_W'(len_eff - LEN_W'(1));

  // input decode
  assign in_idx   = in_tdata[IDX_W-1:0];
  assign in_sym   = in_tdata[IDX_W +: SYM_W];
  assign stall    = s1_valid_r && s1_last_r && skid_valid_r;
  assign in_tready = !stall;
  assign accept   = in_tvalid && in_tready;
  assign acc_text = accept && (in_tuser == OP_TEXT);
  assign acc_load = accept && (in_tuser == OP_LOAD);
  assign acc_last = acc_text && in_tlast;

  // cell row
  assign cnt_chain[0] = '0;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.load_en = acc_load && (in_idx == IDX_W'(k));
    assign ctl.text_en = acc_text && (LEN_W'(k) < len_eff);
    assign ctl.clr     = acc_last;
    assign ctl.is_tail = (tail_idx == IDX_W'(k));

    mhws_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sym      (in_sym),
      .cnt_in   (cnt_chain[k]),
      .cnt_out  (cnt_chain[k+1]),
      .tail_cnt (tail_vec[k])
    );
  end

  always_comb begin
    tail_dist = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      tail_dist = tail_dist | tail_vec[k];
    end
  end

  // text count, saturating at window length
  assign ts_nxt = (ts_r < len_eff) ? ts_r + LEN_W'(1) : len_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= '0;
    end else if (acc_last) begin
      ts_r <= '0;
    end else if (acc_text) begin
      ts_r <= ts_nxt;
    end
  end

  // window distance stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= acc_text;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_text) begin
      s1_last_r <= in_tlast;
      s1_win_r  <= (ts_nxt == len_eff);
      s1_dist_r <= tail_dist;
    end
  end

  // running minimum
  assign fire = s1_valid_r && !stall;
  assign take = s1_win_r && !done_r && (!found_r || (s1_dist_r < best_r));

  always_comb begin
    best_nxt  = best_r;
    found_nxt = found_r;
    done_nxt  = done_r;
    if (take) begin
      best_nxt  = s1_dist_r;
      found_nxt = 1'b1;
      if (thr_cfg_r > s1_dist_r) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r  <= BEST_INIT;
      found_r <= 1'b0;
      done_r  <= 1'b0;
    end else if (fire) begin
      if (s1_last_r) begin
        best_r  <= BEST_INIT;
        found_r <= 1'b0;
        done_r  <= 1'b0;
      end else begin
        best_r  <= best_nxt;
        found_r <= found_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  // result and skid registers
  assign res_new   = fire && s1_last_r;
  assign out_free  = !out_valid_r || out_tready;
  assign res_dist  = found_nxt ? best_nxt : '0;
  assign res_early = done_nxt;
  assign res_nowin = !found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r <= skid_valid_r || res_new;
      end
      if (skid_valid_r) begin
        if (out_free) begin
          skid_valid_r <= 1'b0;
        end
      end else if (res_new && !out_free) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_dist_r  <= skid_dist_r;
        out_early_r <= skid_early_r;
        out_nowin_r <= skid_nowin_r;
      end else if (res_new) begin
        out_dist_r  <= res_dist;
        out_early_r <= res_early;
        out_nowin_r <= res_nowin;
      end
    end
    if (res_new && !out_free) begin
      skid_dist_r  <= res_dist;
      skid_early_r <= res_early;
      skid_nowin_r <= res_nowin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 8'(out_dist_r);
  assign out_tuser  = {out_nowin_r, out_early_r};

endmodule

`default_nettype wire

// File: design/mhws_cell.sv
`default_nettype none

module mhws_cell (
  input  wire                             clk,
  input  wire                             rst_n,
  input  mhws_pkg::cell_ctl_t             ctl,
  input  wire  [mhws_pkg::SYM_W-1:0]      sym,
  input  wire  [mhws_pkg::CNT_W-1:0]      cnt_in,
  output logic [mhws_pkg::CNT_W-1:0]      cnt_out,
  output logic [mhws_pkg::CNT_W-1:0]      tail_cnt
);
  import mhws_pkg::*;

  logic [SYM_W-1:0] pat_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign cnt_nxt  = cnt_in + CNT_W'(pat_r != sym);
  assign cnt_out  = cnt_r;
  assign tail_cnt = ctl.is_tail ? cnt_nxt : '0;

  always_ff @(posedge clk) begin
    if (ctl.load_en) begin
      pat_r <= sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clr) begin
      cnt_r <= '0;
    end else if (ctl.text_en) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
